// File: design/ipmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipmd_pkg
// shared widths, register indexes and constants of the incremental pid drive
// ----------------------------------------------------------------------------
package ipmd_pkg;

  typedef logic signed [12:0] err_t;
  typedef logic signed [13:0] drive_t;
  typedef logic        [9:0]  gain_t;
  typedef logic        [15:0] speed_t;

  typedef enum logic [1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_DERIV_GAIN = 2'd2
  } cfg_reg_e;

  localparam gain_t  PROP_GAIN_RESET  = 10'd180;
  localparam gain_t  INTEG_GAIN_RESET = 10'd15;
  localparam gain_t  DERIV_GAIN_RESET = 10'd10;

  localparam drive_t DRIVE_MAX = 14'sd5000;
  localparam drive_t DRIVE_MIN = -14'sd3500;
  localparam speed_t SPEED_THRESHOLD = 16'd60;

  // reciprocal of 5: (x * 52429) >> 18, exact for the 13 bit error magnitude
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int          RECIP5_SHIFT = 18;
  // reciprocal of 10: (x * 13421773) >> 27, exact for a 23 bit operand
  localparam logic [23:0] RECIP10       = 24'd13421773;
  localparam int          RECIP10_SHIFT = 27;

endpackage : ipmd_pkg
`default_nettype wire

// File: design/incremental_pid_motor_drive.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted item passes the stage one to four registers, then the result register
// throughput: one item per cycle, sustained; each stage holds while the next is full
// the rate is set by the accumulator add and clamp, which closes in stage four each cycle
// reset (synchronous, active high): gains return to 180 / 15 / 10, accumulator and
// error history clear to zero, the pipeline empties
// ----------------------------------------------------------------------------
// incremental_pid_motor_drive
// incremental pid speed loop with speed dependent proportional gain, clamped
// drive accumulator and forward / reverse duty split
// ----------------------------------------------------------------------------
module incremental_pid_motor_drive
  import ipmd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration write port
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [9:0]         cfg_data,
  // item channel
  input  wire logic               item_valid,
  output      logic               item_stall,
  input  wire logic signed [12:0] speed_error,
  input  wire logic [15:0]        measured_speed,
  // result channel
  output      logic               result_valid,
  input  wire logic               result_stall,
  output      logic signed [13:0] drive_value,
  output      logic [12:0]        forward_duty,
  output      logic [11:0]        reverse_duty
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  gain_t prop_gain;
  gain_t integ_gain_tenths;
  gain_t deriv_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain         <= PROP_GAIN_RESET;
      integ_gain_tenths <= INTEG_GAIN_RESET;
      deriv_gain        <= DERIV_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PROP_GAIN:  prop_gain         <= cfg_data;
        CFG_INTEG_GAIN: integ_gain_tenths <= cfg_data;
        CFG_DERIV_GAIN: deriv_gain        <= cfg_data;
        default: ; // index beyond the register list, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control
  // each stage loads when it is empty or its contents move on
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, adv_out;
  logic accept;

  assign adv_out    = !result_valid || !result_stall;
  assign en4        = !v4 || adv_out;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_stall = !en1;
  assign accept     = item_valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en1)     v1           <= accept;
      if (en2)     v2           <= v1;
      if (en3)     v3           <= v2;
      if (en4)     v4           <= v3;
      if (adv_out) result_valid <= v4;
    end
  end

  // --------------------------------------------------------------------------
  // error history, shifted at each accepted item
  // --------------------------------------------------------------------------
  err_t prev_error;
  err_t prev_prev_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error      <= '0;
      prev_prev_error <= '0;
    end else if (accept) begin
      prev_error      <= speed_error;
      prev_prev_error <= prev_error;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: item register, then gain and error differences
  // --------------------------------------------------------------------------
  err_t   s1_e;
  err_t   s1_e1;
  err_t   s1_e2;
  speed_t s1_spd;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_e   <= speed_error;
      s1_e1  <= prev_error;
      s1_e2  <= prev_prev_error;
      s1_spd <= measured_speed;
    end
  end

  logic [12:0]        s1_abs_e;
  logic [28:0]        s1_div5_prod;
  logic [9:0]         s1_abs_div5;
  logic [10:0]        s1_kp_next;
  logic signed [13:0] s1_d1_next;
  logic signed [14:0] s1_d2_next;

  always_comb begin
    // magnitude of the error; the most negative code maps to 4096
    s1_abs_e     = s1_e[12] ? 13'(~s1_e + 13'sd1) : 13'(s1_e);
    s1_div5_prod = s1_abs_e * RECIP5;
    s1_abs_div5  = s1_div5_prod[RECIP5_SHIFT +: 10];
    // extra proportional term only above the speed threshold
    s1_kp_next   = {1'b0, prop_gain} + ((s1_spd > SPEED_THRESHOLD) ? {1'b0, s1_abs_div5}
                                                                   : 11'd0);
    // first difference e - e1
    s1_d1_next   = {s1_e[12], s1_e} - {s1_e1[12], s1_e1};
    // second difference e + e2 - 2*e1
    s1_d2_next   = {{2{s1_e[12]}}, s1_e} + {{2{s1_e2[12]}}, s1_e2}
                 - {s1_e1[12], s1_e1, 1'b0};
  end

  // --------------------------------------------------------------------------
  // stage 2: gain products
  // tenths sum is 10*A + B with A = kp*d1 + kd*d2 and B = ki_tenths*e
  // --------------------------------------------------------------------------
  logic [10:0]        s2_kp;
  logic signed [13:0] s2_d1;
  logic signed [14:0] s2_d2;
  logic [12:0]        s2_abs_e;
  logic               s2_neg_e;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_kp    <= s1_kp_next;
      s2_d1    <= s1_d1_next;
      s2_d2    <= s1_d2_next;
      s2_abs_e <= s1_abs_e;
      s2_neg_e <= s1_e[12];
    end
  end

  logic signed [11:0] s2_kp_s;
  logic signed [10:0] s2_kd_s;
  logic signed [25:0] s2_prop_term;
  logic signed [25:0] s2_deriv_term;
  logic signed [25:0] s2_a_next;
  logic [22:0]        s2_babs_next;

  always_comb begin
    s2_kp_s       = $signed({1'b0, s2_kp});
    s2_kd_s       = $signed({1'b0, deriv_gain});
    s2_prop_term  = s2_kp_s * s2_d1;
    s2_deriv_term = s2_kd_s * s2_d2;
    s2_a_next     = s2_prop_term + s2_deriv_term;
    // integral product kept as magnitude, sign follows the error
    s2_babs_next  = integ_gain_tenths * s2_abs_e;
  end

  // --------------------------------------------------------------------------
  // stage 3: integral part divided by ten, folded into A
  // --------------------------------------------------------------------------
  logic signed [25:0] s3_a;
  logic [22:0]        s3_babs;
  logic               s3_neg_e;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_a     <= s2_a_next;
      s3_babs  <= s2_babs_next;
      s3_neg_e <= s2_neg_e;
    end
  end

  logic [46:0]        s3_div10_prod;
  logic [19:0]        s3_qabs;
  logic [22:0]        s3_q_times10;
  logic signed [20:0] s3_qb;
  logic               s3_rem_nz;
  logic signed [26:0] s3_k_next;

  always_comb begin
    s3_div10_prod = s3_babs * RECIP10;
    s3_qabs       = s3_div10_prod[RECIP10_SHIFT +: 20];
    s3_q_times10  = {s3_qabs, 3'b000} + {2'b00, s3_qabs, 1'b0};
    s3_rem_nz     = (s3_q_times10 != s3_babs);
    s3_qb         = s3_neg_e ? -$signed({1'b0, s3_qabs}) : $signed({1'b0, s3_qabs});
    s3_k_next     = {s3_a[25], s3_a} + {{6{s3_qb[20]}}, s3_qb};
  end

  // --------------------------------------------------------------------------
  // stage 4: truncation fix-up, accumulate and clamp
  // a remainder of opposite sign to the sum moves the sum one step toward zero
  // --------------------------------------------------------------------------
  logic signed [26:0] s4_k;
  logic               s4_rem_neg;
  logic               s4_rem_pos;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_k       <= s3_k_next;
      s4_rem_neg <= s3_rem_nz && s3_neg_e;
      s4_rem_pos <= s3_rem_nz && !s3_neg_e;
    end
  end

  drive_t             drive_acc;
  logic               s4_k_pos;
  logic signed [26:0] s4_inc;
  logic signed [27:0] s4_sum;
  drive_t             drive_acc_next;
  drive_t             s4_neg_drive;

  always_comb begin
    s4_k_pos = !s4_k[26] && (s4_k != 27'sd0);
    if (s4_rem_neg && s4_k_pos) begin
      s4_inc = s4_k - 27'sd1;
    end else if (s4_rem_pos && s4_k[26]) begin
      s4_inc = s4_k + 27'sd1;
    end else begin
      s4_inc = s4_k;
    end
    s4_sum = {{14{drive_acc[13]}}, drive_acc} + {s4_inc[26], s4_inc};
    if (s4_sum > DRIVE_MAX) begin
      drive_acc_next = DRIVE_MAX;
    end else if (s4_sum <= DRIVE_MIN) begin
      drive_acc_next = DRIVE_MIN;
    end else begin
      drive_acc_next = s4_sum[13:0];
    end
    s4_neg_drive = -drive_acc_next;
  end

  // accumulator doubles as the drive value of the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_acc <= '0;
    end else if (v4 && adv_out) begin
      drive_acc <= drive_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && adv_out) begin
      forward_duty <= drive_acc_next[13] ? 13'd0 : drive_acc_next[12:0];
      reverse_duty <= drive_acc_next[13] ? s4_neg_drive[11:0] : 12'd0;
    end
  end

  assign drive_value = drive_acc;

endmodule : incremental_pid_motor_drive
`default_nettype wire

// File: design/ipmd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipmd_checker
// port level checks of the incremental pid drive, bound to the top level
// ----------------------------------------------------------------------------
module ipmd_checker
  import ipmd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [13:0] drive_value,
  input wire logic [12:0]        forward_duty,
  input wire logic [11:0]        reverse_duty
);

  // pipeline empties at reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(drive_value)
      && $stable(forward_duty) && $stable(reverse_duty))
    else $error("stalled result changed");

  // drive stays inside the clamp window
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (drive_value <= DRIVE_MAX) && (drive_value >= DRIVE_MIN))
    else $error("drive value outside clamp window");

  // duty split follows the sign of the drive
  a_duty_split: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (drive_value[13] ?
      (forward_duty == 13'd0 && reverse_duty == 12'((-drive_value) & 14'sh0FFF)) :
      (reverse_duty == 12'd0 && forward_duty == drive_value[12:0])))
    else $error("duty split inconsistent with drive value");

endmodule : ipmd_checker

bind incremental_pid_motor_drive ipmd_checker u_ipmd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .drive_value  (drive_value),
  .forward_duty (forward_duty),
  .reverse_duty (reverse_duty)
);
`default_nettype wire
